FILE: src/swf_pkg.sv
package swf_pkg;

  // Register map
  typedef enum logic [0:0] {
    REG_SYNC_WORD   = 1'b0,
    REG_SAMPLES     = 1'b1
  } reg_idx_e;

  localparam int unsigned CfgDataWidth         = 32;
  localparam int unsigned SamplesWidth         = 9;
  localparam int unsigned DefMaxSamples        = 256;
  localparam logic [31:0] SyncWordReset        = 32'hFECA_FECA;
  localparam logic [8:0]  SamplesPerFrameReset = 9'd256;

  // Phase of the last byte in a four-byte sample group
  localparam logic [1:0] PhaseQLow = 2'd3;

  // Queue between classifier and unpacker
  localparam int unsigned QueueDepth = 2;

  // One payload byte as classified by the front end
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] phase;
    logic [7:0] index;
    logic       last;
  } entry_t;

endpackage

FILE: src/swf_front.sv
module swf_front #(
  parameter int unsigned MaxSamples = swf_pkg::DefMaxSamples
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          sync_word_i,
  input  logic [8:0]           samples_per_frame_i,
  input  logic                 accept_i,
  input  logic [7:0]           data_i,
  output logic                 push_o,
  output swf_pkg::entry_t      entry_o
);
  import swf_pkg::*;

  localparam int unsigned SnW  = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int unsigned CmpW = (SnW + 1 > SamplesWidth) ? SnW + 1 : SamplesWidth;

  typedef enum logic [4:0] {
    ST_SYNC0   = 5'b00001,
    ST_SYNC1   = 5'b00010,
    ST_SYNC2   = 5'b00100,
    ST_SYNC3   = 5'b01000,
    ST_PAYLOAD = 5'b10000
  } hunt_e;

  hunt_e            state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [SnW-1:0]   sample_q, sample_d;
  logic [7:0]       exp_byte;
  logic [CmpW-1:0]  spf_ext, len, count1;
  logic             is_last;

  // Clamp frame length to 1..MaxSamples
  always_comb begin
    spf_ext = CmpW'(samples_per_frame_i);
    if (spf_ext == '0) begin
      len = CmpW'(1);
    end else if (spf_ext > CmpW'(MaxSamples)) begin
      len = CmpW'(MaxSamples);
    end else begin
      len = spf_ext;
    end
    count1  = CmpW'(sample_q) + CmpW'(1);
    is_last = (count1 >= len);
  end

  always_comb begin
    unique case (state_q)
      ST_SYNC0: exp_byte = sync_word_i[31:24];
      ST_SYNC1: exp_byte = sync_word_i[23:16];
      ST_SYNC2: exp_byte = sync_word_i[15:8];
      ST_SYNC3: exp_byte = sync_word_i[7:0];
      default:  exp_byte = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    sample_d = sample_q;
    if (accept_i) begin
      unique case (state_q)
        ST_SYNC0: state_d = (data_i == exp_byte) ? ST_SYNC1 : ST_SYNC0;
        ST_SYNC1: state_d = (data_i == exp_byte) ? ST_SYNC2 : ST_SYNC0;
        ST_SYNC2: state_d = (data_i == exp_byte) ? ST_SYNC3 : ST_SYNC0;
        ST_SYNC3: begin
          if (data_i == exp_byte) begin
            state_d  = ST_PAYLOAD;
            phase_d  = '0;
            sample_d = '0;
          end else begin
            state_d = ST_SYNC0;
          end
        end
        ST_PAYLOAD: begin
          phase_d = phase_q + 2'd1;
          if (phase_q == PhaseQLow) begin
            if (is_last) begin
              state_d  = ST_SYNC0;
              sample_d = '0;
            end else begin
              sample_d = sample_q + SnW'(1);
            end
          end
        end
        default: state_d = ST_SYNC0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SYNC0;
      phase_q  <= '0;
      sample_q <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      sample_q <= sample_d;
    end
  end

  assign push_o        = accept_i && (state_q == ST_PAYLOAD);
  assign entry_o.data  = data_i;
  assign entry_o.phase = phase_q;
  assign entry_o.index = 8'(sample_q);
  assign entry_o.last  = is_last;

endmodule

FILE: src/swf_queue.sv
module swf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  swf_pkg::entry_t  entry_i,
  input  logic             pop_i,
  output swf_pkg::entry_t  entry_o,
  output logic             empty_o,
  output logic             full_o
);
  import swf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assign entry_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(QueueDepth));

endmodule

FILE: src/swf_back.sv
module swf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swf_pkg::entry_t  entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      i_sample_o,
  output logic [15:0]      q_sample_o,
  output logic [7:0]       sample_index_o,
  output logic             last_o
);
  import swf_pkg::*;

  logic [23:0] partial_q;
  logic        valid_q;
  logic [15:0] i_q, q_q;
  logic [7:0]  idx_q;
  logic        last_q;
  logic        out_free, emit;

  // Output slot can take a new sample if empty or being drained now
  assign out_free = !valid_q || !out_stall_i;
  assign pop_o    = !empty_i && ((entry_i.phase != PhaseQLow) || out_free);
  assign emit     = pop_o && (entry_i.phase == PhaseQLow);

  always_ff @(posedge clk_i) begin
    if (pop_o && !emit) begin
      partial_q <= {partial_q[15:0], entry_i.data};
    end
    if (emit) begin
      i_q    <= partial_q[23:8];
      q_q    <= {partial_q[7:0], entry_i.data};
      idx_q  <= entry_i.index;
      last_q <= entry_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = valid_q;
  assign i_sample_o     = i_q;
  assign q_sample_o     = q_q;
  assign sample_index_o = idx_q;
  assign last_o         = last_q;

endmodule

FILE: src/sync_word_iq_frame_deframer.sv
// Sync-word frame aligner with I/Q unpacking. One received byte is taken per
// word on the input channel, one byte every cycle unless stalled. The
// classifier hunts for the four-byte sync word (first byte in
// sync_word[31:24]); a mismatching byte drops the hunt back to the first
// sync byte without being retested. After the sync word it counts
// samples_per_frame groups of four payload bytes (0 acts as 1, values above
// MaxSamples act as MaxSamples). Payload bytes pass through a two-entry
// queue to the unpacker, which builds I = {b0,b1} and Q = {b2,b3} and
// presents one output word per group with its index in the frame and a last
// flag; after the last group the hunt restarts. Input stall rises only when
// the queue is full, which takes a stalled output register plus two further
// payload bytes. Configuration writes take effect at the next edge and
// belong to idle periods.
module sync_word_iq_frame_deframer #(
  parameter int unsigned MaxSamples = swf_pkg::DefMaxSamples
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  // sample output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] i_sample_o,
  output logic [15:0] q_sample_o,
  output logic [7:0]  sample_index_o,
  output logic        last_o
);
  import swf_pkg::*;

  logic [31:0] sync_word_q;
  logic [8:0]  spf_q;
  logic        accept, push, pop, empty, full;
  entry_t      push_entry, head_entry;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= SyncWordReset;
      spf_q       <= SamplesPerFrameReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SYNC_WORD: sync_word_q <= cfg_data_i;
        REG_SAMPLES:   spf_q       <= cfg_data_i[8:0];
        default:       sync_word_q <= sync_word_q;
      endcase
    end
  end

  // Stall input only on a full queue
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  swf_front #(
    .MaxSamples(MaxSamples)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sync_word_i        (sync_word_q),
    .samples_per_frame_i(spf_q),
    .accept_i           (accept),
    .data_i             (data_byte_i),
    .push_o             (push),
    .entry_o            (push_entry)
  );

  swf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .empty_o(empty),
    .full_o (full)
  );

  swf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .i_sample_o    (i_sample_o),
    .q_sample_o    (q_sample_o),
    .sample_index_o(sample_index_o),
    .last_o        (last_o)
  );

endmodule

FILE: verif/tb_sync_word_iq_frame_deframer.sv
`timescale 1ns / 1ps

module tb_sync_word_iq_frame_deframer;

  import swf_pkg::*;

  // Hard ceiling on the run; the slowest legal run stays far below it.
  localparam int CycleLimit = 600000;
  // Random bytes to send after the directed part.
  localparam int RandomBytes = 1100;

  // One expected output word of the unpacker
  typedef struct packed {
    logic [15:0] i_val;
    logic [15:0] q_val;
    logic [7:0]  idx;
    logic        last;
  } iq_sample_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] i_sample_o;
  logic [15:0] q_sample_o;
  logic [7:0]  sample_index_o;
  logic        last_o;

  sync_word_iq_frame_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .i_sample_o     (i_sample_o),
    .q_sample_o     (q_sample_o),
    .sample_index_o (sample_index_o),
    .last_o         (last_o)
  );

  // Bytes waiting to be driven, and samples the deframer still owes us
  logic [7:0] tx_bytes[$];
  iq_sample_t expected_samples[$];

  // Our copy of the configuration registers
  logic [31:0] sync_cfg = SyncWordReset;
  logic [8:0]  spf_cfg  = SamplesPerFrameReset;

  // Our copy of the aligner state
  int          hunt_pos   = 0;
  bit          in_payload = 1'b0;
  logic [9:0]  byte_cnt   = '0;
  logic [23:0] partial    = '0;

  int  error_count = 0;
  int  cycle_count = 0;
  int  in_gap      = 0;
  int  stall_left  = 0;
  bit  in_idle_on  = 1'b1;
  bit  out_idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Frame length in effect: zero acts as one, oversize clamps to the maximum.
  function automatic int effective_len();
    if (spf_cfg == 0) return 1;
    if (spf_cfg > DefMaxSamples) return DefMaxSamples;
    return int'(spf_cfg);
  endfunction

  function automatic logic [7:0] sync_byte(int k);
    return sync_cfg[(3 - k) * 8 +: 8];
  endfunction

  // Advance the aligner copy by one accepted byte and queue any sample it
  // completes.
  task automatic deframe_byte(logic [7:0] b);
    iq_sample_t s;
    int sample_no;
    if (!in_payload) begin
      // A mismatch drops back to the first sync byte; the byte is not retried.
      if (b == sync_byte(hunt_pos)) begin
        if (hunt_pos == 3) begin
          in_payload = 1'b1;
          hunt_pos   = 0;
          byte_cnt   = '0;
        end else begin
          hunt_pos++;
        end
      end else begin
        hunt_pos = 0;
      end
    end else begin
      sample_no = int'(byte_cnt[9:2]);
      if (byte_cnt[1:0] != PhaseQLow) begin
        partial  = {partial[15:0], b};
        byte_cnt = byte_cnt + 10'd1;
      end else begin
        s.i_val = partial[23:8];
        s.q_val = {partial[7:0], b};
        s.idx   = byte_cnt[9:2];
        // Length may have shrunk mid-frame, so end on reaching or passing it.
        s.last  = (sample_no + 1 >= effective_len());
        expected_samples.push_back(s);
        if (s.last) begin
          in_payload = 1'b0;
          hunt_pos   = 0;
          byte_cnt   = '0;
        end else begin
          byte_cnt = byte_cnt + 10'd1;
        end
      end
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == REG_SYNC_WORD) sync_cfg = val;
    else spf_cfg = val[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_byte(logic [7:0] b);
    tx_bytes.push_back(b);
  endtask

  // Queue four bytes, upper byte first.
  task automatic push_word(logic [31:0] w);
    for (int k = 3; k >= 0; k--) tx_bytes.push_back(w[k * 8 +: 8]);
  endtask

  // Wait for every queued byte to go in and every sample to come out, then
  // let the pipeline settle before touching registers.
  task automatic drain();
    while (tx_bytes.size() != 0 || in_valid_i || expected_samples.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Queue one frame with random payload, sometimes preceded by noise or a
  // broken sync word, sometimes with a short or long payload.
  task automatic queue_random_frame(int nsamp);
    int pre;
    int nbytes;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) begin
      pre = $urandom_range(1, 3);
      for (int k = 0; k < pre; k++) push_byte(sync_byte(k));
      push_byte(sync_byte(pre) ^ 8'($urandom_range(1, 255)));
    end
    for (int k = 0; k < 4; k++) push_byte(sync_byte(k));
    nbytes = nsamp * 4;
    if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, nsamp * 4 + 3);
    repeat (nbytes) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Byte driver: take a word on accept, hold it while stalled, otherwise
  // either open an idle burst or present the next pending byte.
  always @(posedge clk_i) begin : byte_driver
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) deframe_byte(data_byte_i);
      if (in_valid_i && in_stall_o) begin
        // hold the stalled word as it is
      end else if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (tx_bytes.size() != 0 && in_idle_on && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 18) - 1;
        in_valid_i <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        in_valid_i  <= 1'b1;
        data_byte_i <= tx_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Sample monitor: compare each accepted word with the oldest expectation
  // and drive random stall bursts on the output.
  always @(posedge clk_i) begin : sample_monitor
    iq_sample_t want;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample i=%h q=%h idx=%0d last=%b",
                                    i_sample_o, q_sample_o, sample_index_o, last_o));
        end else begin
          want = expected_samples.pop_front();
          if (i_sample_o !== want.i_val)
            report_mismatch($sformatf("i_sample got %h want %h", i_sample_o, want.i_val));
          if (q_sample_o !== want.q_val)
            report_mismatch($sformatf("q_sample got %h want %h", q_sample_o, want.q_val));
          if (sample_index_o !== want.idx)
            report_mismatch($sformatf("sample_index got %0d want %0d",
                                      sample_index_o, want.idx));
          if (last_o !== want.last)
            report_mismatch($sformatf("last got %b want %b (idx %0d)",
                                      last_o, want.last, want.idx));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int sent;
    int nfr;
    bit quiet;
    logic [31:0] sw;
    logic [31:0] spf_word;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset sync word, mismatches that drop the hunt without a
    // retry, then two samples at the byte extremes under the reset length.
    push_word(32'hFECA_00FE);
    push_word(32'hFECA_FECA);
    push_byte(8'hFE);
    push_byte(8'hCA);
    push_word(32'hFFFF_0000);
    push_word(32'h0000_FFFF);
    drain();

    // Shrink the length mid-frame below the samples already taken: the next
    // sample must close the frame.
    write_reg(REG_SAMPLES, 32'd1);
    push_word(32'h1234_5678);
    drain();

    // Zero length acts as one; change the sync word halfway through a hunt.
    write_reg(REG_SAMPLES, 32'd0);
    write_reg(REG_SYNC_WORD, 32'h00FF_55AA);
    push_byte(8'h00);
    push_byte(8'hFF);
    drain();
    write_reg(REG_SYNC_WORD, 32'h00FF_A5C3);
    push_byte(8'hA5);
    push_byte(8'hC3);
    push_word(32'h8001_7FFE);
    drain();

    // One frame with an oversize length register: clamps to the maximum and,
    // unless the payload is cut short, walks sample_index up to its top value.
    write_reg(REG_SAMPLES, 32'hFFFF_FFFF);
    write_reg(REG_SYNC_WORD, $urandom());
    queue_random_frame(DefMaxSamples);
    sent = tx_bytes.size();
    drain();

    // Random phases of short frames; registers change only between phases.
    while (sent < RandomBytes) begin
      quiet       = (sent > RandomBytes * 4 / 5);
      in_idle_on  = !quiet && ($urandom_range(0, 3) != 0);
      out_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      if (quiet) begin
        in_gap     = 0;
        stall_left = 0;
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: sw = 32'h0000_0000;
          1: sw = 32'hFFFF_FFFF;
          2: sw = SyncWordReset;
          default: sw = $urandom();
        endcase
        write_reg(REG_SYNC_WORD, sw);
      end
      if ($urandom_range(0, 3) != 0) begin
        // Fill the unused upper bits with junk; only the low nine count.
        spf_word = $urandom();
        case ($urandom_range(0, 7))
          0: spf_word[8:0] = 9'd0;
          1: spf_word[8:0] = 9'd1;
          default: spf_word[8:0] = 9'($urandom_range(1, 8));
        endcase
        write_reg(REG_SAMPLES, spf_word);
      end
      nfr = $urandom_range(2, 6);
      repeat (nfr) queue_random_frame(effective_len());
      sent += tx_bytes.size();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
